>>> sv/assert_macros.svh
// Concurrent assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion clocked on clk, off while rst_n is low.
`define KNST_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Assertion clocked on clk that also holds during reset.
`define KNST_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

>>> sv/knst_pkg.sv
package knst_pkg;

  localparam int unsigned Slots       = 16;
  localparam int unsigned KeyLen      = 8;
  localparam int unsigned SlotIdxW    = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned OccW        = ($clog2(Slots + 1) > 5) ? $clog2(Slots + 1) : 5;
  localparam int unsigned KeyW        = 56;
  localparam int unsigned AddrW       = 32;
  localparam int unsigned CapW        = 16;
  localparam int unsigned LenW        = 16;
  localparam int unsigned CntW        = 32;
  localparam int unsigned CfgW        = 32;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned OpW         = 3;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned KeyCmpBytes = (KeyLen < 7) ? KeyLen : 7;

  // Only the leading key bytes take part in a match.
  localparam logic [KeyW-1:0] KeyCmpMask = {KeyW{1'b1}} >> (8 * (7 - KeyCmpBytes));

  localparam logic [OpW-1:0] OpRegister = 3'd0;
  localparam logic [OpW-1:0] OpRead     = 3'd1;
  localparam logic [OpW-1:0] OpWrite    = 3'd2;
  localparam logic [OpW-1:0] OpDelete   = 3'd3;
  localparam logic [OpW-1:0] OpWear     = 3'd4;

  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StInvalid  = 3'd1;
  localparam logic [StatusW-1:0] StNotFound = 3'd2;
  localparam logic [StatusW-1:0] StNoRoom   = 3'd3;
  localparam logic [StatusW-1:0] StFull     = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgNvmBase   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNvmSize   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWearLimit = 2'd2;

  // Request token walking down the chain.
  typedef struct packed {
    logic            vld;
    logic            active;
    logic [OpW-1:0]  op;
    logic [KeyW-1:0] key;
    logic [AddrW-1:0] addr;
    logic [CapW-1:0] cap;
    logic [LenW-1:0] len;
  } knst_req_t;

  // Lookup result collected along the chain.
  typedef struct packed {
    logic                found;
    logic                free_seen;
    logic [SlotIdxW-1:0] free_idx;
    logic                no_room;
    logic                deleted;
    logic [AddrW-1:0]    addr;
    logic [LenW-1:0]     len;
    logic [CntW-1:0]     writes;
  } knst_res_t;

  // Slot allocation broadcast after a scan.
  typedef struct packed {
    logic                en;
    logic [SlotIdxW-1:0] idx;
    logic [KeyW-1:0]     key;
    logic [AddrW-1:0]    addr;
    logic [CapW-1:0]     cap;
  } knst_alloc_t;

endpackage

>>> sv/knst_cell.sv
module knst_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [knst_pkg::SlotIdxW-1:0] idx_i,
  input  knst_pkg::knst_alloc_t         alloc_i,
  input  knst_pkg::knst_req_t           req_i,
  input  knst_pkg::knst_res_t           res_i,
  output knst_pkg::knst_req_t           req_o,
  output knst_pkg::knst_res_t           res_o
);

  logic                        valid_q, valid_d;
  logic [knst_pkg::KeyW-1:0]   key_q, key_d;
  logic [knst_pkg::AddrW-1:0]  addr_q, addr_d;
  logic [knst_pkg::CapW-1:0]   cap_q, cap_d;
  logic [knst_pkg::LenW-1:0]   len_q, len_d;
  logic [knst_pkg::CntW-1:0]   wr_q, wr_d;
  knst_pkg::knst_req_t         req_q;
  knst_pkg::knst_res_t         res_q, res_d;
  logic                        match;

  assign match = req_i.vld && req_i.active && valid_q && !res_i.found &&
                 (((key_q ^ req_i.key) & knst_pkg::KeyCmpMask) == '0);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    addr_d  = addr_q;
    cap_d   = cap_q;
    len_d   = len_q;
    wr_d    = wr_q;
    res_d   = res_i;
    if (match) begin
      res_d.found  = 1'b1;
      res_d.addr   = addr_q;
      res_d.len    = len_q;
      res_d.writes = wr_q;
      case (req_i.op)
        knst_pkg::OpRegister: begin
          addr_d     = req_i.addr;
          cap_d      = req_i.cap;
          res_d.addr = req_i.addr;
        end
        knst_pkg::OpRead: begin
          res_d.no_room = (req_i.len < len_q);
        end
        knst_pkg::OpWrite: begin
          if (req_i.len > cap_q) begin
            res_d.no_room = 1'b1;
          end else begin
            len_d        = req_i.len;
            wr_d         = (wr_q == '1) ? wr_q : wr_q + 1'b1;
            res_d.len    = req_i.len;
            res_d.writes = wr_d;
          end
        end
        knst_pkg::OpDelete: begin
          valid_d       = 1'b0;
          res_d.deleted = 1'b1;
        end
        default: ;
      endcase
    end else if (req_i.vld && !valid_q && !res_i.free_seen) begin
      res_d.free_seen = 1'b1;
      res_d.free_idx  = idx_i;
    end
    if (alloc_i.en && (alloc_i.idx == idx_i)) begin
      valid_d = 1'b1;
      key_d   = alloc_i.key;
      addr_d  = alloc_i.addr;
      cap_d   = alloc_i.cap;
      len_d   = '0;
      wr_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      req_q   <= '0;
    end else begin
      valid_q <= valid_d;
      req_q   <= req_i;
    end
  end

  // Slot payload and the forwarded result carry no reset.
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    addr_q <= addr_d;
    cap_q  <= cap_d;
    len_q  <= len_d;
    wr_q   <= wr_d;
    if (req_i.vld) begin
      res_q <= res_d;
    end
  end

  assign req_o = req_q;
  assign res_o = res_q;

endmodule

>>> sv/keyed_nvm_slot_table_unit.sv
// Keyed slot table: one request in flight at a time.
// A request walks the row of slot cells, one cell per cycle, then a finish
// state that waits for the output register to be free and loads the result
// into it; no new request is taken until the block is back in idle.
// Reset (async, active low) empties all slots, zeroes the occupancy and
// loads nvm_base = 0, nvm_size = 0, wear_limit = 100000.
module keyed_nvm_slot_table_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [knst_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [knst_pkg::CfgW-1:0]       cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // key[55:0], buffer_address[87:56], capacity[103:88], length[119:104]
  input  logic [119:0]                    s_axis_tdata,
  // opcode[2:0]
  input  logic [2:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // slot_address[31:0], value_length[47:32], writes_done[79:48],
  // wear_exceeded[80], occupancy[85:81], zero[87:86]
  output logic [87:0]                     m_axis_tdata,
  // status[2:0]
  output logic [2:0]                      m_axis_tuser
);

  typedef enum logic [1:0] {StIdle, StScan, StFinish} state_e;

  localparam int unsigned Slots = knst_pkg::Slots;

  state_e state_q, state_d;

  logic [knst_pkg::CfgW-1:0] nvm_base_q, nvm_size_q, wear_limit_q;

  // Input fields
  logic [knst_pkg::OpW-1:0]   in_op;
  logic [knst_pkg::KeyW-1:0]  in_key;
  logic [knst_pkg::AddrW-1:0] in_addr;
  logic [knst_pkg::CapW-1:0]  in_cap;
  logic [knst_pkg::LenW-1:0]  in_len;

  assign in_op   = s_axis_tuser;
  assign in_key  = s_axis_tdata[55:0];
  assign in_addr = s_axis_tdata[87:56];
  assign in_cap  = s_axis_tdata[103:88];
  assign in_len  = s_axis_tdata[119:104];

  // Held request
  logic [knst_pkg::OpW-1:0]   op_q;
  logic                       active_q;
  logic [knst_pkg::KeyW-1:0]  key_q;
  logic [knst_pkg::AddrW-1:0] addr_q;
  logic [knst_pkg::CapW-1:0]  cap_q;

  logic [knst_pkg::KeyW-1:0] key_n;
  logic [2:0]                klen;
  logic                      alive;
  logic [32:0]               win_hi, buf_end;
  logic                      reg_bad, in_active, accept;

  // Cut the key at its first zero byte.
  always_comb begin
    alive = 1'b1;
    klen  = '0;
    key_n = '0;
    for (int b = 0; b < 7; b++) begin
      if (alive && (in_key[8*b +: 8] != 8'd0)) begin
        key_n[8*b +: 8] = in_key[8*b +: 8];
        klen            = klen + 3'd1;
      end else begin
        alive = 1'b0;
      end
    end
  end

  assign win_hi  = {1'b0, nvm_base_q} + {1'b0, nvm_size_q};
  assign buf_end = {1'b0, in_addr} + {17'd0, in_cap};
  assign reg_bad = (in_addr == '0) || (in_cap == '0) ||
                   (int'(klen) >= int'(knst_pkg::KeyLen)) ||
                   (in_addr < nvm_base_q) || (buf_end > win_hi);
  assign in_active = (in_op == knst_pkg::OpRegister) ? !reg_bad :
                     (in_op <= knst_pkg::OpWear);

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Cell chain
  knst_pkg::knst_req_t   req_c [Slots+1];
  knst_pkg::knst_res_t   res_c [Slots+1];
  knst_pkg::knst_alloc_t alloc;

  always_comb begin
    req_c[0].vld    = accept;
    req_c[0].active = in_active;
    req_c[0].op     = in_op;
    req_c[0].key    = key_n;
    req_c[0].addr   = in_addr;
    req_c[0].cap    = in_cap;
    req_c[0].len    = in_len;
  end
  assign res_c[0] = '0;

  for (genvar i = 0; i < Slots; i++) begin : g_cell
    knst_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (knst_pkg::SlotIdxW'(i)),
      .alloc_i (alloc),
      .req_i   (req_c[i]),
      .res_i   (res_c[i]),
      .req_o   (req_c[i+1]),
      .res_o   (res_c[i+1])
    );
  end

  // Finish
  knst_pkg::knst_res_t          last;
  logic                         out_free, finish, has_data, dec;
  logic [knst_pkg::OccW-1:0]    used_q, used_d;
  logic                         m_valid_q, m_valid_d;
  logic [knst_pkg::StatusW-1:0] status_q, status_d;
  logic [knst_pkg::AddrW-1:0]   o_addr_q, o_addr_d;
  logic [knst_pkg::LenW-1:0]    o_len_q, o_len_d;
  logic [knst_pkg::CntW-1:0]    o_wr_q, o_wr_d;
  logic                         o_wear_q, o_wear_d;

  assign last     = res_c[Slots];
  assign out_free = !m_valid_q || m_axis_tready;
  assign finish   = (state_q == StFinish) && out_free;

  always_comb begin
    alloc.en   = finish && active_q && (op_q == knst_pkg::OpRegister) &&
                 !last.found && last.free_seen;
    alloc.idx  = last.free_idx;
    alloc.key  = key_q;
    alloc.addr = addr_q;
    alloc.cap  = cap_q;
  end

  assign has_data = (last.found && !last.deleted) || alloc.en;
  assign dec      = last.found && last.deleted && (used_q != '0);

  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q;
    used_d    = used_q;
    status_d  = status_q;
    o_addr_d  = o_addr_q;
    o_len_d   = o_len_q;
    o_wr_d    = o_wr_q;
    o_wear_d  = o_wear_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (req_c[Slots].vld) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (out_free) begin
          state_d   = StIdle;
          m_valid_d = 1'b1;
          if (!active_q) begin
            status_d = knst_pkg::StInvalid;
          end else if (last.found) begin
            status_d = last.no_room ? knst_pkg::StNoRoom : knst_pkg::StOk;
          end else if (op_q == knst_pkg::OpRegister) begin
            status_d = last.free_seen ? knst_pkg::StOk : knst_pkg::StFull;
          end else begin
            status_d = knst_pkg::StNotFound;
          end
          if (alloc.en) begin
            o_addr_d = addr_q;
            o_len_d  = '0;
            o_wr_d   = '0;
          end else if (has_data) begin
            o_addr_d = last.addr;
            o_len_d  = last.len;
            o_wr_d   = last.writes;
          end else begin
            o_addr_d = '0;
            o_len_d  = '0;
            o_wr_d   = '0;
          end
          o_wear_d = has_data && (o_wr_d >= wear_limit_q);
          used_d   = used_q + knst_pkg::OccW'(alloc.en) - knst_pkg::OccW'(dec);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      m_valid_q <= 1'b0;
      used_q    <= '0;
      status_q  <= knst_pkg::StOk;
      o_addr_q  <= '0;
      o_len_q   <= '0;
      o_wr_q    <= '0;
      o_wear_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      used_q    <= used_d;
      status_q  <= status_d;
      o_addr_q  <= o_addr_d;
      o_len_q   <= o_len_d;
      o_wr_q    <= o_wr_d;
      o_wear_q  <= o_wear_d;
    end
  end

  // Hold the request for the finish state.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= in_op;
      active_q <= in_active;
      key_q    <= key_n;
      addr_q   <= in_addr;
      cap_q    <= in_cap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nvm_base_q   <= '0;
      nvm_size_q   <= '0;
      wear_limit_q <= 32'd100000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        knst_pkg::CfgNvmBase:   nvm_base_q   <= cfg_wdata_i;
        knst_pkg::CfgNvmSize:   nvm_size_q   <= cfg_wdata_i;
        knst_pkg::CfgWearLimit: wear_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {2'b00, used_q[4:0], o_wear_q, o_wr_q, o_len_q, o_addr_q};

endmodule

>>> sv/knst_checker.sv
`include "assert_macros.svh"

module knst_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [87:0]  m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);

  logic        miss;
  logic        out_stall;
  logic [90:0] out_word;
  logic [4:0]  occ;

  assign miss = (m_axis_tuser == knst_pkg::StInvalid) ||
                (m_axis_tuser == knst_pkg::StNotFound) ||
                (m_axis_tuser == knst_pkg::StFull);

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tuser, m_axis_tdata};
  assign occ       = m_axis_tdata[85:81];

  // Stalled result holds.
  `KNST_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid && $stable(out_word))

  // Only one request in flight.
  `KNST_ASSERT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

  // Occupancy never exceeds the table.
  `KNST_ASSERT(a_occ_bound, clk_i, rst_ni, m_axis_tvalid |-> (32'(occ) <= knst_pkg::Slots))

  // No slot data without a matched slot.
  `KNST_ASSERT(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && miss |-> (m_axis_tdata[80:0] == '0))

  // No result right after a reset edge.
  `KNST_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid)

endmodule

bind keyed_nvm_slot_table_unit knst_checker u_knst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
